>>> hw/rtl/clbs_pkg.sv
// shared types, register codes and the segment builder of the lcd bus sequencer
// no dependencies; every other file imports this package
package clbs_pkg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic [2:0] row;
        logic [5:0] column;
    } request_t;

    typedef struct packed {
        logic        register_select;
        logic        enable;
        logic [7:0]  data_pins;
        logic [15:0] hold_us;
        logic        last;
    } segment_t;

    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_CURSOR  = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [1:0] REG_BUS_MODE    = 2'd0;
    localparam logic [1:0] REG_ENABLE_HOLD = 2'd1;
    localparam logic [1:0] REG_COMMAND_GAP = 2'd2;

    localparam logic        BUS_MODE_RESET    = 1'b0;
    localparam logic [15:0] ENABLE_HOLD_RESET = 16'd750;
    localparam logic [15:0] COMMAND_GAP_RESET = 16'd500;

    localparam logic [2:0] ROW_1 = 3'd1;
    localparam logic [2:0] ROW_2 = 3'd2;
    localparam logic [2:0] ROW_3 = 3'd3;
    localparam logic [2:0] ROW_4 = 3'd4;

    localparam logic [7:0] ROW_1_BASE = 8'h80;
    localparam logic [7:0] ROW_2_BASE = 8'hC0;
    localparam logic [7:0] ROW_3_BASE = 8'h94;
    localparam logic [7:0] ROW_4_BASE = 8'hD4;

    typedef enum logic [1:0] {
        PLAN_WIDE,
        PLAN_NIBBLE_DATA,
        PLAN_NIBBLE_CMD
    } plan_t;

    // one classified request waiting for the back end
    typedef struct packed {
        plan_t      plan;
        logic       register_select;
        logic [7:0] code;
    } job_t;

    typedef logic [2:0] step_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic step_t last_step(plan_t plan);
        step_t s;
        case (plan)
            PLAN_WIDE:        s = 3'd1;
            PLAN_NIBBLE_DATA: s = 3'd3;
            PLAN_NIBBLE_CMD:  s = 3'd5;
            default:          s = 3'd1;
        endcase
        return s;
    endfunction

    function automatic segment_t build_segment(job_t job, step_t step,
                                               logic [15:0] hold, logic [15:0] gap);
        segment_t   seg;
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'b0000, job.code[7:4]};
        lo = {4'b0000, job.code[3:0]};
        seg.register_select = job.register_select;
        seg.hold_us = hold;
        case (job.plan)
            PLAN_WIDE:
            begin
                seg.data_pins = job.code;
                seg.enable    = (step == 3'd0);
            end
            PLAN_NIBBLE_DATA:
            begin
                seg.data_pins = (step < 3'd2) ? hi : lo;
                seg.enable    = ~step[0];
            end
            PLAN_NIBBLE_CMD:
            begin
                seg.data_pins = (step < 3'd2) ? hi : lo;
                seg.enable    = (step == 3'd0) || (step == 3'd4);
                // two low-enable gaps before the second nibble pulse
                if ((step == 3'd2) || (step == 3'd3))
                    seg.hold_us = gap;
            end
            default:
            begin
                seg.data_pins = job.code;
                seg.enable    = (step == 3'd0);
            end
        endcase
        seg.last = (step == last_step(job.plan));
        return seg;
    endfunction

endpackage

>>> hw/rtl/clbs_front.sv
// front end: classifies a request into a job (plan, register select, byte)
// depends on clbs_pkg
module clbs_front (
    input  clbs_pkg::request_t request,
    input  logic               bus_mode,
    output clbs_pkg::job_t     job,
    output logic               job_valid
);
    import clbs_pkg::*;

    logic [7:0] base;
    logic       row_ok;
    logic [5:0] col_m1;
    logic [7:0] cursor_code;

    always_comb
    begin
        row_ok = 1'b1;
        case (request.row)
            ROW_1:   base = ROW_1_BASE;
            ROW_2:   base = ROW_2_BASE;
            ROW_3:   base = ROW_3_BASE;
            ROW_4:   base = ROW_4_BASE;
            default:
            begin
                base   = ROW_1_BASE;
                row_ok = 1'b0;
            end
        endcase
        // column zero counts as column one
        col_m1 = (request.column == 6'd0) ? 6'd0 : request.column - 6'd1;
        cursor_code = base + {2'b00, col_m1};
    end

    always_comb
    begin
        job.register_select = 1'b0;
        job.code            = request.byte_value;
        job_valid           = 1'b1;
        case (request.operation)
            OP_COMMAND: ;
            OP_DATA:    job.register_select = 1'b1;
            OP_CURSOR:
            begin
                job.code  = cursor_code;
                job_valid = row_ok;
            end
            default:    job_valid = 1'b0;
        endcase
        if (bus_mode)
            job.plan = PLAN_WIDE;
        else if (job.register_select)
            job.plan = PLAN_NIBBLE_DATA;
        else
            job.plan = PLAN_NIBBLE_CMD;
    end

endmodule

>>> hw/rtl/clbs_job_fifo.sv
// two-entry job queue between the front and the back end
// depends on clbs_pkg
module clbs_job_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  clbs_pkg::job_t           wr_job,
    input  logic                     pop,
    output clbs_pkg::job_t           rd_job,
    output clbs_pkg::fifo_status_t   status
);
    import clbs_pkg::*;

    job_t       store_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_job       = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

>>> hw/rtl/clbs_back.sv
// back end: steps through a job's pin segments into a two-entry result queue
// depends on clbs_pkg
module clbs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  clbs_pkg::job_t          job,
    input  clbs_pkg::fifo_status_t  job_status,
    input  logic [15:0]             hold,
    input  logic [15:0]             gap,
    input  logic                    pop,
    output logic                    job_pop,
    output clbs_pkg::segment_t      segment,
    output logic                    empty
);
    import clbs_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    segment_t   seg;
    logic       emit;
    logic       out_pop;
    segment_t   out_reg [2];
    logic       out_wr_reg;
    logic       out_wr_next;
    logic       out_rd_reg;
    logic       out_rd_next;
    logic [1:0] out_count_reg;
    logic [1:0] out_count_next;

    assign seg     = build_segment(job, step_reg, hold, gap);
    assign emit    = !job_status.empty && (out_count_reg != 2'd2);
    assign job_pop = emit && seg.last;
    assign empty   = (out_count_reg == 2'd0);
    assign out_pop = pop && !empty;
    assign segment = out_reg[out_rd_reg];

    always_comb
    begin
        step_next = step_reg;
        if (emit)
            step_next = seg.last ? 3'd0 : step_reg + 3'd1;
        out_wr_next    = out_wr_reg ^ emit;
        out_rd_next    = out_rd_reg ^ out_pop;
        out_count_next = out_count_reg + {1'b0, emit} - {1'b0, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_wr_reg    <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            step_reg      <= step_next;
            out_wr_reg    <= out_wr_next;
            out_rd_reg    <= out_rd_next;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg[out_wr_reg] <= seg;
    end

endmodule

>>> hw/rtl/char_lcd_bus_sequencer_core.sv
// channel   handshake            payload
// request   push / full          request_t  (operation, byte_value, row, column)
// segment   empty / pop          segment_t  (register_select, enable, data_pins,
//                                            hold_us, last)
// config    cfg_valid/cfg_ready  cfg_index (2b), cfg_data (16b)
//
// a request yields 2, 4 or 6 pin segments (8-bit bus, 4-bit data, 4-bit command)
// in the back end, one per cycle while the segment queue has room; the segment
// stepper sets the rate. requests with a bad row or operation code 3 give nothing.
// a two-entry job queue and a two-entry segment queue let each side stall alone.
// reset empties both queues and loads the register defaults; no clearing pass.
// depends on clbs_pkg, clbs_front, clbs_job_fifo, clbs_back
module char_lcd_bus_sequencer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  clbs_pkg::request_t  request,
    output logic                empty,
    input  logic                pop,
    output clbs_pkg::segment_t  segment,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import clbs_pkg::*;

    logic         bus_mode_reg;
    logic [15:0]  enable_hold_reg;
    logic [15:0]  command_gap_reg;
    job_t         front_job;
    logic         front_valid;
    logic         job_push;
    job_t         head_job;
    fifo_status_t job_status;
    logic         job_pop;

    assign cfg_ready = 1'b1;
    assign full      = job_status.full;
    assign job_push  = push && !job_status.full && front_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg    <= BUS_MODE_RESET;
            enable_hold_reg <= ENABLE_HOLD_RESET;
            command_gap_reg <= COMMAND_GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BUS_MODE:    bus_mode_reg    <= cfg_data[0];
                REG_ENABLE_HOLD: enable_hold_reg <= cfg_data;
                REG_COMMAND_GAP: command_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    clbs_front u_front (
        .request   (request),
        .bus_mode  (bus_mode_reg),
        .job       (front_job),
        .job_valid (front_valid)
    );

    clbs_job_fifo u_job_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (front_job),
        .pop    (job_pop),
        .rd_job (head_job),
        .status (job_status)
    );

    clbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .job_status (job_status),
        .hold       (enable_hold_reg),
        .gap        (command_gap_reg),
        .pop        (pop),
        .job_pop    (job_pop),
        .segment    (segment),
        .empty      (empty)
    );

    // an enable-high phase is never the closing segment of a request
    a_enable_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && segment.enable) |-> !segment.last)
        else $error("enable-high segment marked last");

    // on the nibble bus the upper data pins stay low
    a_nibble_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !bus_mode_reg) |-> (segment.data_pins[7:4] == 4'd0))
        else $error("upper data pins driven in 4-bit mode");

    // a segment whose hold is not the enable hold is a low-enable gap
    a_gap_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (segment.hold_us != enable_hold_reg)) |-> !segment.enable)
        else $error("gap segment with enable high");

endmodule
